// ----- rtl/iaal_pkg.sv -----
// Shared types and constants for the indexed array list.
`default_nettype none

package iaal_pkg;

   // Payload widths fixed by the interface
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned POS_W   = 7;
   localparam int unsigned COUNT_W = 7;

   // Capacity range; command fields are sized for the largest one
   localparam int unsigned CAPACITY_DEF = 64;
   localparam int unsigned CAPACITY_MAX = 1024;
   localparam int unsigned CNT_MAX_W    = $clog2(CAPACITY_MAX + 1);

   // Request codes
   typedef enum logic [1:0] {
      KIND_READ   = 2'd0,
      KIND_INSERT = 2'd1,
      KIND_APPEND = 2'd2,
      KIND_DELETE = 2'd3
   } iaal_kind_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_DONE  = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } iaal_status_type;

   // What the cell row does this cycle
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_APPEND = 2'd2,
      OP_DELETE = 2'd3
   } iaal_op_type;

   // Command broadcast to every cell
   typedef struct packed {
      iaal_op_type            op;
      logic [CNT_MAX_W-1:0]   pos;
      logic [CNT_MAX_W-1:0]   count;
      logic [DATA_W-1:0]      value;
   } iaal_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/iaal_cell.sv -----
// One list slot: holds an entry and shifts toward or away from its neighbors.
`default_nettype none

module iaal_cell #(
   parameter int unsigned IDX = 0
) (
   input  logic                        clock,
   input  iaal_pkg::iaal_cmd_type      cmd,
   input  logic [iaal_pkg::DATA_W-1:0] left_data,
   input  logic [iaal_pkg::DATA_W-1:0] right_data,
   output logic [iaal_pkg::DATA_W-1:0] data,
   output logic [iaal_pkg::DATA_W-1:0] sel_data
);
   import iaal_pkg::*;

   localparam logic [CNT_MAX_W-1:0] IDX_C = CNT_MAX_W'(IDX);

   logic [DATA_W-1:0] data_ff;
   logic [DATA_W-1:0] data_in;

   // Next entry: load, take from a neighbor, or hold
   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (IDX_C == cmd.pos) begin
               data_in = cmd.value;
            end else if (IDX_C > cmd.pos) begin
               data_in = left_data;
            end
         end
         OP_APPEND: begin
            if (IDX_C == cmd.count) begin
               data_in = cmd.value;
            end
         end
         OP_DELETE: begin
            if (IDX_C >= cmd.pos) begin
               data_in = right_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

   // Drive the read bus only when this slot is addressed
   assign sel_data = (IDX_C == cmd.pos) ? data_ff : '0;

endmodule

`default_nettype wire

// ----- rtl/iaal_ctrl.sv -----
// Request decode, entry count and registered result for the list.
`default_nettype none

module iaal_ctrl #(
   parameter int unsigned CAPACITY = iaal_pkg::CAPACITY_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_type,
   input  logic [iaal_pkg::POS_W-1:0]   req_position,
   input  logic [iaal_pkg::DATA_W-1:0]  req_value,
   input  logic [iaal_pkg::DATA_W-1:0]  read_bus,
   output iaal_pkg::iaal_cmd_type       cmd,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [iaal_pkg::DATA_W-1:0]  rsp_read_data,
   output logic [1:0]                   rsp_status,
   output logic [iaal_pkg::COUNT_W-1:0] rsp_item_count,
   output logic                         rsp_is_empty
);
   import iaal_pkg::*;

   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam logic [CNT_MAX_W-1:0] CAP_C = CNT_MAX_W'(CAPACITY);

   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic [CNT_MAX_W-1:0] cnt_ext;
   logic [CNT_MAX_W-1:0] pos_ext;
   logic [CNT_MAX_W-1:0] cnt_next_ext;
   logic                 accept;
   iaal_kind_type        kind;
   iaal_op_type          op;
   iaal_status_type      status;
   logic [DATA_W-1:0]    rd_data;

   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic [DATA_W-1:0]    rsp_read_data_ff;
   logic [1:0]           rsp_status_ff;
   logic [COUNT_W-1:0]   rsp_item_count_ff;
   logic                 rsp_is_empty_ff;

   assign accept    = req_valid && !req_stall;
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign kind      = iaal_kind_type'(req_type);
   assign cnt_ext   = CNT_MAX_W'(count_ff);
   assign pos_ext   = CNT_MAX_W'(req_position);

   // Decode: range and fullness checks pick the status and the row operation
   always_comb begin
      op      = OP_HOLD;
      status  = STATUS_DONE;
      rd_data = '0;
      case (kind)
         KIND_READ: begin
            if (pos_ext < cnt_ext) begin
               rd_data = read_bus;
            end else begin
               status = STATUS_RANGE;
            end
         end
         KIND_INSERT: begin
            if (pos_ext > cnt_ext) begin
               status = STATUS_RANGE;
            end else if (cnt_ext >= CAP_C) begin
               status = STATUS_FULL;
            end else begin
               op = OP_INSERT;
            end
         end
         KIND_APPEND: begin
            if (cnt_ext >= CAP_C) begin
               status = STATUS_FULL;
            end else begin
               op = OP_APPEND;
            end
         end
         KIND_DELETE: begin
            if (pos_ext >= cnt_ext) begin
               status = STATUS_RANGE;
            end else begin
               op = OP_DELETE;
            end
         end
         default: begin
            op = OP_HOLD;
         end
      endcase
   end

   // Count after this transaction
   always_comb begin
      count_in = count_ff;
      if (accept) begin
         case (op)
            OP_INSERT, OP_APPEND: count_in = count_ff + 1'b1;
            OP_DELETE:            count_in = count_ff - 1'b1;
            default:              count_in = count_ff;
         endcase
      end
   end

   assign cnt_next_ext = CNT_MAX_W'(count_in);

   // Command to the cell row; only an accepted transaction moves entries
   assign cmd.op    = accept ? op : OP_HOLD;
   assign cmd.pos   = pos_ext;
   assign cmd.count = cnt_ext;
   assign cmd.value = req_value;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Result register
   always_comb begin
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_read_data_ff  <= rd_data;
         rsp_status_ff     <= status;
         rsp_item_count_ff <= cnt_next_ext[COUNT_W-1:0];
         rsp_is_empty_ff   <= (cnt_next_ext == '0);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_data  = rsp_read_data_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_item_count = rsp_item_count_ff;
   assign rsp_is_empty   = rsp_is_empty_ff;

   // Checks
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CNT_MAX_W'(count_ff) <= CAP_C)
      else $error("entry count above capacity");

   a_append_grows: assert property (@(posedge clock) disable iff (reset)
      accept && kind == KIND_APPEND && cnt_ext < CAP_C
      |=> count_ff == $past(count_ff) + 1'b1)
      else $error("append did not grow the list");

   a_fail_holds: assert property (@(posedge clock) disable iff (reset)
      accept && status != STATUS_DONE |=> count_ff == $past(count_ff))
      else $error("failed transaction changed the count");

   a_fail_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STATUS_DONE |-> rsp_read_data_ff == '0)
      else $error("failed transaction returned data");

   a_result_tracks: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && rsp_is_empty_ff == (count_ff == '0))
      else $error("result does not match the count");

endmodule

`default_nettype wire

// ----- rtl/indexed_array_list.sv -----
// Top level: bounded ordered list of unsigned words held in a row of shifting cells.
// A result is registered in the cycle after its transaction is accepted.
// Throughput: one transaction per cycle unless stalled; every cell updates its
// entry from a neighbor in the same cycle and a read selects one cell onto an OR bus.
// Reset clears the entry count and the result valid flag; entries are not cleared.
`default_nettype none

module indexed_array_list #(
   parameter int unsigned CAPACITY = iaal_pkg::CAPACITY_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_type,
   input  logic [iaal_pkg::POS_W-1:0]   req_position,
   input  logic [iaal_pkg::DATA_W-1:0]  req_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [iaal_pkg::DATA_W-1:0]  rsp_read_data,
   output logic [1:0]                   rsp_status,
   output logic [iaal_pkg::COUNT_W-1:0] rsp_item_count,
   output logic                         rsp_is_empty
);
   import iaal_pkg::*;

   iaal_cmd_type      cmd;
   logic [DATA_W-1:0] cell_data [CAPACITY];
   logic [DATA_W-1:0] sel_data  [CAPACITY];
   logic [DATA_W-1:0] read_bus;

   iaal_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_value      (req_value),
      .read_bus       (read_bus),
      .cmd            (cmd),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_read_data  (rsp_read_data),
      .rsp_status     (rsp_status),
      .rsp_item_count (rsp_item_count),
      .rsp_is_empty   (rsp_is_empty)
   );

   // Row of cells; inner cells see two neighbors, the ends see cmd.value and zero
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic [DATA_W-1:0] left_data;
      logic [DATA_W-1:0] right_data;

      if (i == 0) begin : g_first
         assign left_data = cmd.value;
      end else begin : g_left
         assign left_data = cell_data[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_data = '0;
      end else begin : g_right
         assign right_data = cell_data[i+1];
      end

      iaal_cell #(
         .IDX (i)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_data),
         .right_data (right_data),
         .data       (cell_data[i]),
         .sel_data   (sel_data[i])
      );
   end

   // Read bus: at most one cell drives nonzero data
   always_comb begin
      read_bus = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         read_bus = read_bus | sel_data[i];
      end
   end

endmodule

`default_nettype wire
